### rtl/core/tccw_pkg.sv
// ============================================================================
// tccw_pkg
// Shared types and constants for the text console cursor writer.
// ============================================================================
`default_nettype none

package tccw_pkg;

  // Default grid size
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Character codes and reset attribute
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd15;

  // Request codes
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Input transaction
  typedef struct packed {
    logic        req_type;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [10:0] cursor_pos;
  } out_t;

  // One store entry: character plus attribute
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] attr;
  } cell_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK,
    ST_WRITE,
    ST_DONE
  } tccw_state_t;

endpackage

`default_nettype wire

### rtl/core/tccw_store.sv
// ============================================================================
// tccw_store
// Character/attribute store: one write port, one read port, registered read.
// ============================================================================
`default_nettype none

module tccw_store
  import tccw_pkg::*;
#(
  parameter int CELLS = DEF_ROWS * DEF_COLUMNS,
  parameter int AW    = $clog2(CELLS)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire cell_t         wr_cell,
  input  wire logic [AW-1:0] rd_addr,
  output cell_t              rd_cell
);

  cell_t mem [CELLS];
  cell_t rd_cell_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_cell;
    end
  end

  // Read port, data registered
  always_ff @(posedge clk) begin
    rd_cell_r <= mem[rd_addr];
  end

  assign rd_cell = rd_cell_r;

endmodule

`default_nettype wire

### rtl/core/tccw_seq.sv
// ============================================================================
// tccw_seq
// Sequencer: cursor state, request decode and one walk counter shared by the
// post-reset clear, the scroll copy, the row blank and the full-grid clear.
// ============================================================================
`default_nettype none

module tccw_seq
  import tccw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  // request side
  input  wire logic  in_valid,
  input  wire in_t   in_data,
  output logic       busy,
  // attribute register
  input  wire logic [7:0] attr,
  // result side
  output logic       res_valid,
  input  wire logic  res_ready,
  output out_t       res_data,
  // store port
  output logic       wr_en,
  output logic [$clog2(ROWS*COLUMNS)-1:0] wr_addr,
  output cell_t      wr_cell,
  output logic [$clog2(ROWS*COLUMNS)-1:0] rd_addr,
  input  wire cell_t rd_cell
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int MOVED = (ROWS - 1) * COLUMNS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);

  localparam logic [PW-1:0] K_MOVED = PW'(MOVED);
  localparam logic [PW-1:0] K_LAST  = PW'(CELLS - 1);
  localparam logic [PW-1:0] K_COLS  = PW'(COLUMNS);
  localparam logic [RW-1:0] R_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] C_END   = CW'(COLUMNS);

  tccw_state_t   state_r, state_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    chr_r, chr_nxt;
  logic          clear_r, clear_nxt;
  logic          range_r, range_nxt;
  logic [7:0]    res_char_r, res_char_nxt;
  logic [7:0]    res_attr_r, res_attr_nxt;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      k_r     <= '0;
      row_r   <= '0;
      col_r   <= '0;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    chr_r      <= chr_nxt;
    clear_r    <= clear_nxt;
    range_r    <= range_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
  end

  // Next state and store control
  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    pos_nxt      = pos_r;
    chr_nxt      = chr_r;
    clear_nxt    = clear_r;
    range_nxt    = range_r;
    res_char_nxt = res_char_r;
    res_attr_nxt = res_attr_r;
    wr_en        = 1'b0;
    wr_addr      = AW'(pos_r);
    wr_cell      = '{ch: chr_r, attr: attr};
    rd_addr      = AW'(in_data.cell_index);
    res_valid    = 1'b0;

    unique case (state_r)
      // post-reset clear pass, constant reset attribute
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_addr = AW'(k_r);
        wr_cell = '{ch: CH_SPACE, attr: ATTR_RESET};
        if (k_r == K_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          res_char_nxt = '0;
          res_attr_nxt = '0;
          if (in_data.req_type == REQ_READ) begin
            range_nxt = (17'(in_data.cell_index) < 17'(CELLS));
            state_nxt = ST_READ;
          end else if (in_data.char_code == CH_NEWLINE) begin
            if (row_r == R_LAST) begin
              k_nxt     = '0;
              state_nxt = ST_SCROLL;
            end else begin
              row_nxt   = row_r + 1'b1;
              col_nxt   = '0;
              pos_nxt   = pos_r - PW'(col_r) + K_COLS;
              state_nxt = ST_DONE;
            end
          end else if (in_data.char_code == CH_BACKSPACE && col_r != '0) begin
            col_nxt   = col_r - 1'b1;
            pos_nxt   = pos_r - 1'b1;
            state_nxt = ST_DONE;
          end else if (col_r == C_END && row_r == R_LAST) begin
            // rows overflow: clear grid, then write at the origin
            chr_nxt   = in_data.char_code;
            clear_nxt = 1'b1;
            k_nxt     = '0;
            state_nxt = ST_BLANK;
          end else begin
            // ordinary write; a column wrap advances the linear position by one like any other write
            wr_en   = 1'b1;
            wr_cell = '{ch: in_data.char_code, attr: attr};
            if (col_r == C_END) begin
              row_nxt = row_r + 1'b1;
              col_nxt = CW'(1);
            end else begin
              col_nxt = col_r + 1'b1;
            end
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ST_DONE;
          end
        end
      end

      // read data arrives in the cycle after the address
      ST_READ: begin
        res_char_nxt = range_r ? rd_cell.ch   : '0;
        res_attr_nxt = range_r ? rd_cell.attr : '0;
        state_nxt    = ST_DONE;
      end

      // copy cell k+COLUMNS to k, the write lands in the cycle after its read
      ST_SCROLL: begin
        rd_addr = AW'(k_r + K_COLS);
        if (k_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(k_r - 1'b1);
          wr_cell = rd_cell;
        end
        if (k_r == K_MOVED) begin
          clear_nxt = 1'b0;
          state_nxt = ST_BLANK;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // blank from k up to the last cell
      ST_BLANK: begin
        wr_en   = 1'b1;
        wr_addr = AW'(k_r);
        wr_cell = '{ch: CH_SPACE, attr: attr};
        if (k_r == K_LAST) begin
          col_nxt = '0;
          if (clear_r) begin
            row_nxt   = '0;
            pos_nxt   = '0;
            state_nxt = ST_WRITE;
          end else begin
            row_nxt   = R_LAST;
            pos_nxt   = K_MOVED;
            state_nxt = ST_DONE;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // held byte after a full clear
      ST_WRITE: begin
        wr_en     = 1'b1;
        col_nxt   = col_r + 1'b1;
        pos_nxt   = pos_r + 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  assign res_data = '{cell_char:  res_char_r,
                      cell_attr:  res_attr_r,
                      cursor_pos: 11'(17'(pos_r))};

endmodule

`default_nettype wire

### rtl/core/text_console_cursor_writer_unit.sv
// ============================================================================
// text_console_cursor_writer_unit
// Text console engine: character/attribute grid with a cursor, put and read.
// ============================================================================
//
//  Channel  Direction  Handshake        Payload
//  in_      input      in_valid/stall   in_t  (req_type, char_code, cell_index)
//  out_     output     out_valid/stall  out_t (cell_char, cell_attr, cursor_pos)
//  cfg_     input      cfg_valid/ready  8-bit text attribute
//
//  Ordinary put or backspace: IDLE then DONE; read: IDLE, READ, then DONE,
//  set by the single store write and read port plus the result register.
//  Newline past the bottom row: copy walk then blank of the last row; put
//  with row overflow: blank of the whole grid, then the held byte written.
//  After reset a clearing pass over all ROWS*COLUMNS cells (2000 by default)
//  runs with in_stall high; configuration writes are taken throughout.
//  A waiting result holds in the output register; the next transaction is
//  accepted meanwhile and its result waits until the register frees.
// ============================================================================
`default_nettype none

module text_console_cursor_writer_unit
  import tccw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_t        in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_t            out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  logic          busy;
  logic          res_valid;
  logic          res_ready;
  out_t          res_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  cell_t         wr_cell;
  logic [AW-1:0] rd_addr;
  cell_t         rd_cell;
  logic [7:0]    attr_r;
  logic          out_valid_r;
  out_t          out_r;

  // Attribute register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_data;
    end
  end

  // Sequencer
  tccw_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .busy      (busy),
    .attr      (attr_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_cell   (wr_cell),
    .rd_addr   (rd_addr),
    .rd_cell   (rd_cell)
  );

  // Grid store
  tccw_store #(
    .CELLS (CELLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_cell (wr_cell),
    .rd_addr (rd_addr),
    .rd_cell (rd_cell)
  );

  assign in_stall = busy;

  // Output register
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted back to back");

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("no clearing pass after reset");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (17'(out_data.cursor_pos) <= 17'(CELLS)))
    else $error("cursor position past the grid");

  a_store_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_stall && !in_valid) |-> !wr_en)
    else $error("store written while idle");

endmodule

`default_nettype wire
